// File: sv/mchc_pkg.sv
// ============================================================================
// mchc_pkg
// Shared types and constants of the circle hit counter.
// ============================================================================
package mchc_pkg;

    localparam logic [31:0] BASE_SEED_RST = 32'hDEAD_BEEF;
    localparam logic [31:0] MIX_GOLDEN    = 32'h9e37_79b9;
    localparam logic [31:0] MIX_MUL1      = 32'h85eb_ca6b;
    localparam logic [31:0] MIX_MUL2      = 32'hc2b2_ae35;
    localparam logic [32:0] HIT_MAX       = {33{1'b1}};
    // 1.0 less one ulp below it (2^-24), in units of 2^-25
    localparam logic [26:0] HIT_LIMIT     = 27'(33554430);

    typedef struct packed {
        logic [31:0] seed;
        logic        first;
        logic        last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX1,
        ST_MIX2,
        ST_MIX3,
        ST_GEN1,
        ST_GEN2,
        ST_LOAD,
        ST_NORM,
        ST_ROUND,
        ST_SQR,
        ST_FIX,
        ST_DONE
    } t_state;

endpackage

// File: sv/mchc_fifo.sv
// ============================================================================
// mchc_fifo
// Two-entry job queue between the front and the back.
// ============================================================================
module mchc_fifo
    import mchc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_wr_en,
    input  t_job    i_wr_job,
    input  logic    i_rd_en,
    output t_job    o_rd_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_wr_en && !i_rd_en) begin
                r_count <= r_count + 2'd1;
            end else if (!i_wr_en && i_rd_en) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

    assign o_rd_job     = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == 2'd2);
    assign o_stat.empty = (r_count == 2'd0);

endmodule

// File: sv/mchc_front.sv
// ============================================================================
// mchc_front
// Holds the base seed and turns each accepted item into a seeded job.
// ============================================================================
module mchc_front
    import mchc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready,
    input  logic        i_push,
    input  logic [31:0] i_sample_index,
    input  logic        i_first,
    input  logic        i_last,
    input  t_q_stat     i_q_stat,
    output logic        o_wr_en,
    output t_job        o_wr_job
);

    logic [31:0] r_base_seed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_seed <= BASE_SEED_RST;
        end else if (i_cfg_valid) begin
            r_base_seed <= i_cfg_data;
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_wr_en        = i_push && !i_q_stat.full;
    // seed wraps mod 2^32
    assign o_wr_job.seed  = i_sample_index + r_base_seed;
    assign o_wr_job.first = i_first;
    assign o_wr_job.last  = i_last;

endmodule

// File: sv/mchc_back.sv
// ============================================================================
// mchc_back
// Sequencer: seed mixing, generator steps, float squares, hit test, count.
// ============================================================================
module mchc_back
    import mchc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_job        i_job,
    output logic        o_rd_en,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_inside_res,
    output logic [32:0] o_hit_total,
    output logic        o_run_done
);

    t_state r_state;
    t_state n_state;

    logic [31:0] r_acc;
    logic [31:0] r_p;
    logic [31:0] r_s [4];
    logic [1:0]  r_i;
    logic        r_k;
    logic [31:0] r_raw [2];
    logic [25:0] r_f [2];
    logic [31:0] r_n;
    logic signed [5:0] r_e;
    logic [23:0] r_m;
    logic        r_zero;
    logic [47:0] r_sq;
    logic        r_first;
    logic        r_last;
    logic [32:0] r_hits;
    logic        r_out_valid;
    logic        r_out_inside;
    logic        r_out_done;

    logic        out_free;
    logic        hit;
    logic [32:0] hits_base;
    logic [31:0] acc_add;
    logic [31:0] mix_w;
    logic [31:0] gen_t;
    logic [24:0] m_sum;
    logic        m_up;
    logic        sq_n;
    logic [47:0] sq_norm;
    logic [24:0] q_sum;
    logic        q_ov;
    logic [23:0] q_val;
    logic signed [7:0] shamt;
    logic [25:0] f_val;

    assign out_free = !r_out_valid || i_pop;
    assign o_rd_en  = (r_state == ST_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (!i_q_stat.empty) n_state = ST_MIX1;
            ST_MIX1:  n_state = ST_MIX2;
            ST_MIX2:  n_state = ST_MIX3;
            ST_MIX3:  n_state = (r_i == 2'd3) ? ST_GEN1 : ST_MIX1;
            ST_GEN1:  n_state = ST_GEN2;
            ST_GEN2:  n_state = r_k ? ST_LOAD : ST_GEN1;
            ST_LOAD:  n_state = ST_NORM;
            ST_NORM:  if (r_n == 32'd0 || r_n[31]) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_SQR;
            ST_SQR:   n_state = ST_FIX;
            ST_FIX:   n_state = r_k ? ST_DONE : ST_LOAD;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // SplitMix32 pieces
    assign acc_add = r_acc + MIX_GOLDEN;
    assign mix_w   = acc_add ^ (acc_add >> 16);
    // xoshiro128** scrambler, first half
    assign gen_t   = r_s[1] * 32'd5;

    // int to float, round to nearest even
    assign m_up  = r_n[7] && ((|r_n[6:0]) || r_n[8]);
    assign m_sum = {1'b0, r_n[31:8]} + {24'd0, m_up};

    // square rounding
    assign sq_n    = ~r_sq[47];
    assign sq_norm = sq_n ? {r_sq[46:0], 1'b0} : r_sq;
    assign q_sum   = {1'b0, sq_norm[47:24]}
                     + {24'd0, sq_norm[23] && ((|sq_norm[22:0]) || sq_norm[24])};
    assign q_ov    = q_sum[24];
    assign q_val   = q_ov ? 24'h80_0000 : q_sum[23:0];
    // square in units of 2^-25 is q_val * 2^-(shamt)
    assign shamt   = 8'(2 * 8'(r_e)) + 8'(sq_n) - 8'(q_ov) - 8'sd1;

    always_comb begin
        if (r_zero) begin
            f_val = 26'd0;
        end else if (shamt < 0) begin
            f_val = {2'b00, q_val} << 2'(-shamt);
        end else if (shamt > 8'sd25) begin
            f_val = 26'd0;
        end else begin
            f_val = {2'b00, q_val} >> 5'(shamt);
        end
    end

    assign hit       = ({1'b0, r_f[0]} + {1'b0, r_f[1]}) <= HIT_LIMIT;
    assign hits_base = r_first ? 33'd0 : r_hits;

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_acc   <= i_job.seed;
                r_first <= i_job.first;
                r_last  <= i_job.last;
                r_i     <= 2'd0;
            end
            ST_MIX1: begin
                r_acc <= acc_add;
                r_p   <= mix_w * MIX_MUL1;
            end
            ST_MIX2: begin
                r_p <= (r_p ^ (r_p >> 13)) * MIX_MUL2;
            end
            ST_MIX3: begin
                r_s[r_i] <= r_p ^ (r_p >> 16);
                r_i      <= r_i + 2'd1;
                r_k      <= 1'b0;
            end
            ST_GEN1: begin
                r_p <= gen_t;
            end
            ST_GEN2: begin
                r_raw[r_k] <= {r_p[24:0], r_p[31:25]} * 32'd9;
                r_s[2]     <= r_s[2] ^ r_s[0] ^ (r_s[1] << 9);
                r_s[3]     <= {r_s[3][20:0] ^ r_s[1][20:0],
                               r_s[3][31:21] ^ r_s[1][31:21]};
                r_s[1]     <= r_s[1] ^ r_s[2] ^ r_s[0];
                r_s[0]     <= r_s[0] ^ r_s[3] ^ r_s[1];
                r_k        <= ~r_k;
            end
            ST_LOAD: begin
                r_n <= r_raw[r_k];
                r_e <= 6'sd0;
            end
            ST_NORM: begin
                if (r_n != 32'd0 && !r_n[31]) begin
                    r_n <= {r_n[30:0], 1'b0};
                    r_e <= r_e + 6'sd1;
                end
            end
            ST_ROUND: begin
                r_zero <= (r_n == 32'd0);
                if (m_sum[24]) begin
                    r_m <= 24'h80_0000;
                    r_e <= r_e - 6'sd1;
                end else begin
                    r_m <= m_sum[23:0];
                end
            end
            ST_SQR: begin
                r_sq <= r_m * r_m;
            end
            ST_FIX: begin
                r_f[r_k] <= f_val;
                r_k      <= ~r_k;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits      <= 33'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                if (hit && hits_base != HIT_MAX) begin
                    r_hits <= hits_base + 33'd1;
                end else begin
                    r_hits <= hits_base;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out_inside <= hit;
            r_out_done   <= r_last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_inside_res = r_out_inside;
    assign o_hit_total  = r_hits;
    assign o_run_done   = r_out_done;

endmodule

// File: sv/monte_carlo_circle_hit_counter_unit.sv
// ============================================================================
// monte_carlo_circle_hit_counter_unit
// Monte Carlo point generator, unit circle test and running hit count.
// ============================================================================
// Use:
//   Input queue side: drive the sample index, first and last flags and
//   raise push; an item is taken on a clock edge with push high and full
//   low. Up to two items wait in the job queue while the back works.
//   Result queue side: while empty is low the oldest result is on the
//   o_ ports; pop high on an edge takes it. One result per item.
//   Configuration: a write with i_cfg_valid high replaces the base seed
//   (o_cfg_ready is always high); write it only while the block is idle.
//   Sequencing: the back sequencer runs the seed mixing, then the
//   generator steps, then per coordinate the one-bit normalising
//   shifter, which shifts once per leading zero of the random word,
//   plus rounding and the squarer; time per item depends on the words.
//   Items do not overlap; the back starts a new item only when idle.
//   Reset (synchronous, active low) clears the queues, the hit count and
//   sets the base seed to its default.
//   When the receiver stalls, hold the finished result in the output
//   register; the back waits, and the front keeps filling its queue.
// ============================================================================
module monte_carlo_circle_hit_counter_unit
    import mchc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_sample_index,
    input  logic        i_first,
    input  logic        i_last,
    output logic        empty,
    input  logic        pop,
    output logic        o_inside_res,
    output logic [32:0] o_hit_total,
    output logic        o_run_done
);

    t_q_stat q_stat;
    t_job    wr_job;
    t_job    rd_job;
    logic    wr_en;
    logic    rd_en;

    // front: seed each item and queue it
    mchc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .o_cfg_ready    (o_cfg_ready),
        .i_push         (push),
        .i_sample_index (i_sample_index),
        .i_first        (i_first),
        .i_last         (i_last),
        .i_q_stat       (q_stat),
        .o_wr_en        (wr_en),
        .o_wr_job       (wr_job)
    );

    mchc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_job (wr_job),
        .i_rd_en  (rd_en),
        .o_rd_job (rd_job),
        .o_stat   (q_stat)
    );

    // back: generate the point, test it, count it
    mchc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_job        (rd_job),
        .o_rd_en      (rd_en),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_inside_res (o_inside_res),
        .o_hit_total  (o_hit_total),
        .o_run_done   (o_run_done)
    );

    assign full = q_stat.full;

endmodule

// File: tb/tb_monte_carlo_circle_hit_counter_unit.sv
// ============================================================================
// tb_monte_carlo_circle_hit_counter_unit
// Self-checking bench for the circle hit counter: a bit-exact predictor of
// the seed mixer, generator, binary32 circle test and hit count, with random
// idling on both queue sides, base seed changes between phases and a long
// receiver hold-off that fills the block up.
// ============================================================================
module tb_monte_carlo_circle_hit_counter_unit
    import mchc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int DRAIN_CYCLES  = 120;   // beyond the slowest item latency
    localparam int HOLDOFF_LEN   = 400;
    localparam int STALL_LIMIT   = 5000;  // cycles with nothing accepted
    localparam int ITEMS_PER_PH  = 168;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts one result per accepted item and checks results
    // ------------------------------------------------------------------------
    typedef struct {
        logic        inside_res;
        logic [32:0] hit_total;
        logic        run_done;
    } t_hit_result;

    // value = mant * 2^expo
    typedef struct {
        logic [23:0] mant;
        int          expo;
    } t_bin32_val;

    class circle_hit_scoreboard;
        logic [31:0] base_seed;
        logic [32:0] hits_so_far;
        t_hit_result pending_results[$];
        int          mismatches;

        function new();
            base_seed   = BASE_SEED_RST;
            hits_so_far = '0;
            mismatches  = 0;
        endfunction

        static function logic [31:0] rotl(logic [31:0] v, int k);
            return (v << k) | (v >> (32 - k));
        endfunction

        static function logic [31:0] mix_step(ref logic [31:0] acc);
            logic [31:0] w;
            acc = acc + MIX_GOLDEN;
            w   = acc;
            w   = (w ^ (w >> 16)) * MIX_MUL1;
            w   = (w ^ (w >> 13)) * MIX_MUL2;
            return w ^ (w >> 16);
        endfunction

        static function logic [31:0] xoshiro_step(ref logic [31:0] s[4]);
            logic [31:0] r;
            logic [31:0] t;
            r = rotl(s[1] * 32'd5, 7) * 32'd9;
            t = s[1] << 9;
            s[2] ^= s[0];
            s[3] ^= s[1];
            s[1] ^= s[2];
            s[0] ^= s[3];
            s[2] ^= t;
            s[3] = rotl(s[3], 11);
            return r;
        endfunction

        // Round an exact value v * 2^e to 24 significant bits, nearest even
        static function t_bin32_val round_to_bin32(logic [127:0] v, int e);
            t_bin32_val   res;
            logic [127:0] q;
            logic [127:0] rem;
            logic [127:0] half;
            int          p;
            int          sh;
            res.mant = '0;
            res.expo = e;
            if (v == '0) return res;
            for (p = 127; p > 0 && !v[p]; p--) ;
            if (p <= 23) begin
                res.mant = v[23:0];
                return res;
            end
            sh   = p - 23;
            q    = v >> sh;
            rem  = v & ((128'd1 << sh) - 1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q = q + 1;
            if (q[24]) begin
                q  = q >> 1;
                sh = sh + 1;
            end
            res.mant = q[23:0];
            res.expo = e + sh;
            return res;
        endfunction

        static function logic point_inside(logic [31:0] rx, logic [31:0] ry);
            t_bin32_val fx, fy, xx, yy, sm;
            int         emin;
            fx = round_to_bin32({96'd0, rx}, -32);
            fy = round_to_bin32({96'd0, ry}, -32);
            xx = round_to_bin32(128'(fx.mant) * 128'(fx.mant), 2 * fx.expo);
            yy = round_to_bin32(128'(fy.mant) * 128'(fy.mant), 2 * fy.expo);
            emin = (xx.expo < yy.expo) ? xx.expo : yy.expo;
            sm = round_to_bin32((128'(xx.mant) << (xx.expo - emin)) +
                                (128'(yy.mant) << (yy.expo - emin)), emin);
            if (sm.mant == '0) return 1'b1;
            if (sm.expo >= 0) return 1'b0;
            return 128'(sm.mant) < (128'd1 << (-sm.expo));
        endfunction

        function void note_sample(logic [31:0] idx, logic first, logic last);
            logic [31:0] acc;
            logic [31:0] s[4];
            logic [31:0] rx, ry;
            t_hit_result res;
            acc = idx + base_seed;   // wraps mod 2^32
            for (int i = 0; i < 4; i++) s[i] = mix_step(acc);
            rx = xoshiro_step(s);
            ry = xoshiro_step(s);
            res.inside_res = point_inside(rx, ry);
            if (first) hits_so_far = '0;
            if (res.inside_res && hits_so_far != HIT_MAX) hits_so_far++;
            res.hit_total = hits_so_far;
            res.run_done  = last;
            pending_results.push_back(res);
        endfunction

        task report_mismatch(string what, logic [32:0] got, logic [32:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH %s: got %0h, want %0h at %0t", what, got, want, $realtime);
        endtask

        task check_result(logic ins, logic [32:0] cnt, logic done);
            t_hit_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", cnt, '0);
                return;
            end
            want = pending_results.pop_front();
            if (ins !== want.inside_res)
                report_mismatch("inside_res", 33'(ins), 33'(want.inside_res));
            if (cnt !== want.hit_total)
                report_mismatch("hit_total", cnt, want.hit_total);
            if (done !== want.run_done)
                report_mismatch("run_done", 33'(done), 33'(want.run_done));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block and its signals
    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data = '0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_sample_index = '0;
    logic        i_first = 1'b0;
    logic        i_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_inside_res;
    logic [32:0] o_hit_total;
    logic        o_run_done;

    circle_hit_scoreboard hit_board = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    bit holdoff_req     = 1'b0;
    int quiet_cycles    = 0;

    monte_carlo_circle_hit_counter_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_sample_index (i_sample_index),
        .i_first        (i_first),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_inside_res   (o_inside_res),
        .o_hit_total    (o_hit_total),
        .o_run_done     (o_run_done)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request.
    // Outputs are read right after the rising edge, before the block updates.
    initial begin
        int holdoff_left;
        holdoff_left = 0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req && holdoff_left == 0) begin
                holdoff_left = HOLDOFF_LEN;
                holdoff_req  = 1'b0;
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(posedge i_clk);
            if (pop && !empty)
                hit_board.check_result(o_inside_res, o_hit_total, o_run_done);
        end
    end

    // Offer one item; hold it until the block takes it
    task send_sample(logic [31:0] idx, logic first, logic last);
        while ($urandom_range(99) < sender_idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push           <= 1'b1;
        i_sample_index <= idx;
        i_first        <= first;
        i_last         <= last;
        do @(posedge i_clk); while (full);
        hit_board.note_sample(idx, first, last);
    endtask

    // Drain every expected result, let the block settle, then write the seed
    task write_base_seed(logic [31:0] seed);
        @(negedge i_clk);
        push <= 1'b0;
        while (hit_board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        hit_board.base_seed = seed;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function logic [31:0] pick_index();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'(-hit_board.base_seed) + 32'($urandom_range(3)) - 32'd2;
            default: return $urandom();
        endcase
    endfunction

    task random_samples(int count);
        for (int n = 0; n < count; n++)
            send_sample(pick_index(), $urandom_range(19) == 0, $urandom_range(19) == 0);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default seed, counting from reset without a first flag,
        // index extremes and seed wrap, every flag pairing
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h2152_4110, 1'b0, 1'b0);   // seed becomes all ones; the next item wraps it to zero
        send_sample(32'h2152_4111, 1'b0, 1'b1);
        send_sample(32'h0000_0001, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1, 1'b1);
        send_sample(32'h5555_5555, 1'b0, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b0, 1'b1);
        for (int n = 0; n < 8; n++) send_sample(n, n == 0, n == 7);

        // Phase: no idling, default seed
        random_samples(ITEMS_PER_PH);

        // Phase: sender mostly idle, seed zero
        write_base_seed(32'h0000_0000);
        send_sample(32'h0000_0000, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        sender_idle_pct = 81;
        random_samples(ITEMS_PER_PH);

        // Phase: receiver mostly stalling, seed all ones
        write_base_seed(32'hFFFF_FFFF);
        send_sample(32'h0000_0001, 1'b1, 1'b0);
        sender_idle_pct = 0;
        recv_stall_pct  = 81;
        random_samples(ITEMS_PER_PH);

        // Phase: both sides idle now and then, random seed
        write_base_seed($urandom());
        sender_idle_pct = 28;
        recv_stall_pct  = 28;
        random_samples(ITEMS_PER_PH);

        // Phase: long receiver hold-off while the sender keeps offering,
        // so the queues fill and full stalls the input
        write_base_seed($urandom());
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        holdoff_req     = 1'b1;
        random_samples(ITEMS_PER_PH);

        @(negedge i_clk);
        push <= 1'b0;
        while (hit_board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (hit_board.mismatches == 0 && hit_board.pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
